@@ hw/rtl/rbeta_pkg.sv @@
// Package for the rolling beta block: widths, constants and helper functions.
// Used by rbeta_div, rolling_beta_from_returns_top and the testbench; no dependencies.
`timescale 1ns / 1ps
package rbeta_pkg;

	localparam int WINDOW_MAX  = 64;
	localparam int SLOT_W      = $clog2(WINDOW_MAX);
	localparam int WIN_W       = 7;
	localparam int WIN_RESET   = 20;
	localparam int WIN_MIN     = 2;

	localparam int DIV_NW      = 72;
	localparam int DIV_DW      = 64;
	localparam int DIV_CW      = 7;

	localparam logic [22:0] PCT_SCALE = 23'd6553600;

	localparam logic [1:0] ST_VALID = 2'd0;
	localparam logic [1:0] ST_WARM  = 2'd1;
	localparam logic [1:0] ST_ZERO  = 2'd2;

	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	function automatic logic signed [31:0] sat32(input logic signed [72:0] v);
		logic signed [72:0] hi;
		logic signed [72:0] lo;
		hi = 73'sh7FFF_FFFF;
		lo = -73'sh8000_0000;
		if (v > hi)
			return S32_MAX;
		else if (v < lo)
			return S32_MIN;
		else
			return v[31:0];
	endfunction

	// product / 65536, truncated toward zero
	function automatic logic signed [47:0] trunc16(input logic signed [63:0] p);
		logic signed [63:0] t;
		t = p[63] ? (p + 64'sd65535) : p;
		return t[63:16];
	endfunction

endpackage

@@ hw/rtl/rolling_beta_from_returns_top.sv @@
// Top level of the rolling beta block: sequencer, change rings, shared multiplier.
// Depends on rbeta_pkg and rbeta_div.
//
// Usage:
// - Input channel (in_valid/in_stall) carries one beat of asset and market
//   prices. in_stall is high while an item is being worked on.
// - Output channel (out_valid/out_stall) gives one beat per input beat:
//   beta_value (signed Q16.16) and status (0 valid, 1 warm-up, 2 zero variance).
// - The first item after reset only stores the prices; a warm-up item computes
//   two percent changes. A full item computes two percent changes, sums the W
//   ring entries, divides for the two means, accumulates the W deviation
//   products, then divides for cov, var and beta; the shared 72-step divider
//   dominates.
// - The next input beat is taken while a result still waits in the output
//   register; the sequencer holds in its last step while out_stall is high
//   and a result is still pending.
// - Reset clears previous prices, slot and item count; window_length returns
//   to 20 and variance_unbiased to 1. Ring contents are not cleared.
// - Configuration (cfg_wr_en, cfg_index, cfg_data) must be written only while idle; the block does not check.
`timescale 1ns / 1ps
module rolling_beta_from_returns_top import rbeta_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic                cfg_index,
	input  logic [WIN_W-1:0]    cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [31:0]         asset_price,
	input  logic [31:0]         market_price,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  beta_value,
	output logic [1:0]          status
);

	localparam logic [4:0] S_IDLE      = 5'd0;
	localparam logic [4:0] S_PCT_GO    = 5'd1;
	localparam logic [4:0] S_PCT_WAIT  = 5'd2;
	localparam logic [4:0] S_WRITE     = 5'd3;
	localparam logic [4:0] S_SUM_RD    = 5'd4;
	localparam logic [4:0] S_SUM_ACC   = 5'd5;
	localparam logic [4:0] S_MEAN_GO   = 5'd6;
	localparam logic [4:0] S_MEAN_WAIT = 5'd7;
	localparam logic [4:0] S_DEV_RD    = 5'd8;
	localparam logic [4:0] S_DEV_D     = 5'd9;
	localparam logic [4:0] S_MUL_XY    = 5'd10;
	localparam logic [4:0] S_MUL_XX    = 5'd11;
	localparam logic [4:0] S_ACC_XX    = 5'd12;
	localparam logic [4:0] S_COV_GO    = 5'd13;
	localparam logic [4:0] S_COV_WAIT  = 5'd14;
	localparam logic [4:0] S_VAR_GO    = 5'd15;
	localparam logic [4:0] S_VAR_WAIT  = 5'd16;
	localparam logic [4:0] S_BETA_GO   = 5'd17;
	localparam logic [4:0] S_BETA_WAIT = 5'd18;
	localparam logic [4:0] S_DONE      = 5'd19;

	localparam logic CFG_WINDOW   = 1'b0;
	localparam logic CFG_UNBIASED = 1'b1;

	logic [4:0]              state_q;
	logic [WIN_W-1:0]        window_q;
	logic                    unbiased_q;
	logic [31:0]             prev_a_q, prev_m_q;
	logic [31:0]             ap_q, mp_q;
	logic [SLOT_W-1:0]       slot_q;
	logic [WIN_W-1:0]        seen_q;
	logic [WIN_W-1:0]        w_q, wv_q;
	logic [WIN_W-1:0]        k_q;
	logic                    sel_q;
	logic                    neg_q;
	logic [31:0]             chg_a_q, chg_m_q;
	logic signed [37:0]      sum_a_q, sum_m_q;
	logic signed [32:0]      mean_a_q, mean_m_q;
	logic signed [31:0]      da_q, dm_q;
	logic signed [63:0]      prod_q;
	logic signed [53:0]      sxy_q, sxx_q;
	logic signed [53:0]      cov_q;
	logic [53:0]             var_q;
	logic                    out_valid_q;
	logic signed [31:0]      res_beta_q, beta_q;
	logic [1:0]              res_status_q, status_q;

	logic [31:0]             ring_a_q [WINDOW_MAX];
	logic [31:0]             ring_m_q [WINDOW_MAX];
	logic [31:0]             rd_a_q, rd_m_q;
	logic [SLOT_W-1:0]       rd_idx;

	logic                    div_start;
	logic [DIV_NW-1:0]       div_num;
	logic [DIV_DW-1:0]       div_den;
	logic                    div_neg;
	logic                    div_done;
	logic [DIV_NW-1:0]       div_quo;
	logic signed [72:0]      div_s;

	logic [WIN_W-1:0]        w_clamp;
	logic [31:0]             p_sel, prev_sel;
	logic signed [32:0]      diff;
	logic [31:0]             diff_mag;
	logic signed [37:0]      sum_sel;
	logic [37:0]             sum_mag;
	logic [52:0]             cov_mag;
	logic [WIN_W:0]          seen_inc;
	logic [WIN_W:0]          seen_cap;
	logic [WIN_W-1:0]        seen_next;
	logic signed [33:0]      dev_a, dev_m;
	logic signed [31:0]      mul_a;
	logic                    out_free;

	assign w_clamp = (window_q < WIN_W'(WIN_MIN)) ? WIN_W'(WIN_MIN) :
		(window_q > WIN_W'(WINDOW_MAX)) ? WIN_W'(WINDOW_MAX) : window_q;

	assign p_sel    = sel_q ? mp_q : ap_q;
	assign prev_sel = sel_q ? prev_m_q : prev_a_q;
	assign diff     = $signed({1'b0, p_sel}) - $signed({1'b0, prev_sel});
	assign diff_mag = diff[32] ? 32'(-diff) : diff[31:0];

	assign sum_sel  = sel_q ? sum_m_q : sum_a_q;
	assign sum_mag  = sum_sel[37] ? 38'(-sum_sel) : 38'(sum_sel);
	assign cov_mag  = cov_q[53] ? 53'(-cov_q) : cov_q[52:0];

	assign seen_inc  = {1'b0, seen_q} + (WIN_W+1)'(1);
	assign seen_cap  = {1'b0, w_q} + (WIN_W+1)'(1);
	assign seen_next = (seen_inc > seen_cap) ? seen_cap[WIN_W-1:0] : seen_inc[WIN_W-1:0];

	assign rd_idx = slot_q - SLOT_W'(1) - k_q[SLOT_W-1:0];

	assign dev_a = {{2{rd_a_q[31]}}, rd_a_q} - {mean_a_q[32], mean_a_q};
	assign dev_m = {{2{rd_m_q[31]}}, rd_m_q} - {mean_m_q[32], mean_m_q};

	assign mul_a = (state_q == S_MUL_XY) ? da_q : dm_q;

	assign div_s = neg_q ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		div_neg   = 1'b0;
		case (state_q)
			S_PCT_GO: begin
				div_start = (prev_sel != 32'd0);
				div_num   = DIV_NW'({23'd0, diff_mag} * PCT_SCALE);
				div_den   = DIV_DW'(prev_sel);
				div_neg   = diff[32];
			end
			S_MEAN_GO: begin
				div_start = 1'b1;
				div_num   = DIV_NW'(sum_mag);
				div_den   = DIV_DW'(w_q);
				div_neg   = sum_sel[37];
			end
			S_COV_GO: begin
				div_start = 1'b1;
				div_num   = DIV_NW'(sxy_q[53] ? 54'(-sxy_q) : 54'(sxy_q));
				div_den   = DIV_DW'(w_q);
				div_neg   = sxy_q[53];
			end
			S_VAR_GO: begin
				div_start = 1'b1;
				div_num   = DIV_NW'(sxx_q);
				div_den   = DIV_DW'(wv_q);
			end
			S_BETA_GO: begin
				div_start = 1'b1;
				div_num   = DIV_NW'({cov_mag, 16'd0});
				div_den   = DIV_DW'(var_q);
				div_neg   = cov_q[53];
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	rbeta_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// change rings
	always_ff @(posedge clk) begin
		if (state_q == S_WRITE) begin
			ring_a_q[slot_q] <= chg_a_q;
			ring_m_q[slot_q] <= chg_m_q;
		end
		rd_a_q <= ring_a_q[rd_idx];
		rd_m_q <= ring_m_q[rd_idx];
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q   <= WIN_W'(WIN_RESET);
			unbiased_q <= 1'b1;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_WINDOW:   window_q   <= cfg_data;
				CFG_UNBIASED: unbiased_q <= cfg_data[0];
				default:      window_q   <= window_q;
			endcase
		end
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			prev_a_q    <= '0;
			prev_m_q    <= '0;
			slot_q      <= '0;
			seen_q      <= '0;
			out_valid_q <= 1'b0;
			sel_q       <= 1'b0;
			k_q         <= '0;
		end else begin
			if (state_q == S_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (seen_q == '0) begin
							prev_a_q <= asset_price;
							prev_m_q <= market_price;
							seen_q   <= WIN_W'(1);
							state_q  <= S_DONE;
						end else begin
							sel_q   <= 1'b0;
							state_q <= S_PCT_GO;
						end
					end
				end
				S_PCT_GO: begin
					if (prev_sel == 32'd0) begin
						sel_q   <= 1'b1;
						state_q <= sel_q ? S_WRITE : S_PCT_GO;
					end else begin
						state_q <= S_PCT_WAIT;
					end
				end
				S_PCT_WAIT: begin
					if (div_done) begin
						sel_q   <= 1'b1;
						state_q <= sel_q ? S_WRITE : S_PCT_GO;
					end
				end
				S_WRITE: begin
					slot_q   <= slot_q + SLOT_W'(1);
					prev_a_q <= ap_q;
					prev_m_q <= mp_q;
					seen_q   <= seen_next;
					k_q      <= '0;
					if ({1'b0, seen_next} < seen_cap)
						state_q <= S_DONE;
					else
						state_q <= S_SUM_RD;
				end
				S_SUM_RD: state_q <= S_SUM_ACC;
				S_SUM_ACC: begin
					k_q <= k_q + WIN_W'(1);
					if (k_q == w_q - WIN_W'(1)) begin
						sel_q   <= 1'b0;
						state_q <= S_MEAN_GO;
					end else begin
						state_q <= S_SUM_RD;
					end
				end
				S_MEAN_GO: state_q <= S_MEAN_WAIT;
				S_MEAN_WAIT: begin
					if (div_done) begin
						sel_q <= 1'b1;
						k_q   <= '0;
						state_q <= sel_q ? S_DEV_RD : S_MEAN_GO;
					end
				end
				S_DEV_RD: state_q <= S_DEV_D;
				S_DEV_D:  state_q <= S_MUL_XY;
				S_MUL_XY: state_q <= S_MUL_XX;
				S_MUL_XX: state_q <= S_ACC_XX;
				S_ACC_XX: begin
					k_q <= k_q + WIN_W'(1);
					state_q <= (k_q == w_q - WIN_W'(1)) ? S_COV_GO : S_DEV_RD;
				end
				S_COV_GO: state_q <= S_COV_WAIT;
				S_COV_WAIT: begin
					if (div_done)
						state_q <= S_VAR_GO;
				end
				S_VAR_GO: state_q <= S_VAR_WAIT;
				S_VAR_WAIT: begin
					if (div_done)
						state_q <= (div_quo == '0) ? S_DONE : S_BETA_GO;
				end
				S_BETA_GO: state_q <= S_BETA_WAIT;
				S_BETA_WAIT: begin
					if (div_done)
						state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				ap_q         <= asset_price;
				mp_q         <= market_price;
				w_q          <= w_clamp;
				wv_q         <= unbiased_q ? (w_clamp - WIN_W'(1)) : w_clamp;
				res_beta_q   <= '0;
				res_status_q <= ST_WARM;
				sum_a_q      <= '0;
				sum_m_q      <= '0;
				sxy_q        <= '0;
				sxx_q        <= '0;
			end
			S_PCT_GO: begin
				neg_q <= div_neg;
				if (prev_sel == 32'd0) begin
					if (sel_q)
						chg_m_q <= (diff > 33'sd0) ? S32_MAX : 32'd0;
					else
						chg_a_q <= (diff > 33'sd0) ? S32_MAX : 32'd0;
				end
			end
			S_PCT_WAIT: begin
				if (div_done) begin
					if (sel_q)
						chg_m_q <= sat32(div_s);
					else
						chg_a_q <= sat32(div_s);
				end
			end
			S_SUM_ACC: begin
				sum_a_q <= sum_a_q + 38'($signed(rd_a_q));
				sum_m_q <= sum_m_q + 38'($signed(rd_m_q));
			end
			S_MEAN_GO: neg_q <= div_neg;
			S_MEAN_WAIT: begin
				if (div_done) begin
					if (sel_q)
						mean_m_q <= div_s[32:0];
					else
						mean_a_q <= div_s[32:0];
				end
			end
			S_DEV_D: begin
				da_q <= sat32(73'(dev_a));
				dm_q <= sat32(73'(dev_m));
			end
			S_MUL_XY: prod_q <= mul_a * dm_q;
			S_MUL_XX: begin
				sxy_q  <= sxy_q + 54'(trunc16(prod_q));
				prod_q <= mul_a * dm_q;
			end
			S_ACC_XX: sxx_q <= sxx_q + 54'(trunc16(prod_q));
			S_COV_GO: neg_q <= div_neg;
			S_COV_WAIT: begin
				if (div_done)
					cov_q <= div_s[53:0];
			end
			S_VAR_GO: neg_q <= div_neg;
			S_VAR_WAIT: begin
				if (div_done) begin
					var_q <= div_quo[53:0];
					if (div_quo == '0) begin
						res_status_q <= ST_ZERO;
						res_beta_q   <= '0;
					end
				end
			end
			S_BETA_GO: neg_q <= div_neg;
			S_BETA_WAIT: begin
				if (div_done) begin
					res_beta_q   <= sat32(div_s);
					res_status_q <= ST_VALID;
				end
			end
			S_DONE: begin
				if (out_free) begin
					beta_q   <= res_beta_q;
					status_q <= res_status_q;
				end
			end
			default: begin
				neg_q <= neg_q;
			end
		endcase
	end

	assign in_stall   = (state_q != S_IDLE);
	assign out_valid  = out_valid_q;
	assign beta_value = beta_q;
	assign status     = status_q;

endmodule

@@ hw/rtl/rbeta_div.sv @@
// Shared restoring divider for the rolling beta block, one quotient bit a cycle.
// Unsigned magnitudes only; depends on rbeta_pkg.
`timescale 1ns / 1ps
module rbeta_div import rbeta_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_NW-1:0] num,
	input  logic [DIV_DW-1:0] den,
	output logic              done,
	output logic [DIV_NW-1:0] quo
);

	logic [DIV_DW:0]   rem_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_CW-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_DW:0]   trial;
	logic              fits;

	assign trial = {rem_q[DIV_DW-1:0], quo_q[DIV_NW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == DIV_CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CW'(DIV_NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CW'(1);
				if (cnt_q == DIV_CW'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? (trial - {1'b0, den_q}) : trial;
			quo_q <= {quo_q[DIV_NW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

@@ verif/testbench.sv @@
// Testbench for rolling_beta_from_returns_top: random and directed price pairs,
// checked against a built-in rolling beta predictor. Depends on rbeta_pkg and the RTL.
`timescale 1ns / 1ps
module testbench;
	import rbeta_pkg::*;

	typedef struct packed {
		logic [31:0] asset;
		logic [31:0] market;
	} price_pair_t;

	typedef struct packed {
		logic signed [31:0] beta;
		logic [1:0]         stat;
	} beta_result_t;

	localparam int CYCLE_LIMIT = 3_000_000;

	logic               clk;
	logic               arst_n;
	logic               cfg_wr_en;
	logic               cfg_index;
	logic [WIN_W-1:0]   cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic [31:0]        asset_price;
	logic [31:0]        market_price;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] beta_value;
	logic [1:0]         status;

	rolling_beta_from_returns_top dut (.*);

	// predictor state
	int unsigned    win_reg;
	bit             unbiased_reg;
	logic [31:0]    prev_asset, prev_market;
	logic [31:0]    asset_ring [WINDOW_MAX];
	logic [31:0]    market_ring [WINDOW_MAX];
	int unsigned    slot;
	int unsigned    seen_count;

	price_pair_t    pending_pairs[$];
	beta_result_t   expected_betas[$];
	int             error_count;
	longint         cycle_count;
	int             send_gap;
	int             stall_len;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic logic [31:0] percent_change(logic [31:0] now, logic [31:0] prev);
		longint diff;
		diff = longint'({32'd0, now}) - longint'({32'd0, prev});
		if (prev == 0) return diff > 0 ? 32'h7FFF_FFFF : 32'h0;
		return 32'(clamp32((diff * 64'sd6553600) / longint'({32'd0, prev})));
	endfunction

	function automatic beta_result_t predict_beta(price_pair_t p);
		beta_result_t r;
		int unsigned w, wv, idx;
		longint sum_a, sum_m, mean_a, mean_m, sxy, sxx, da, dm, cov, var_m;
		w = win_reg < 2 ? 2 : (win_reg > WINDOW_MAX ? WINDOW_MAX : win_reg);
		if (seen_count != 0) begin
			asset_ring[slot] = percent_change(p.asset, prev_asset);
			market_ring[slot] = percent_change(p.market, prev_market);
			slot = (slot + 1) % WINDOW_MAX;
		end
		prev_asset = p.asset;
		prev_market = p.market;
		seen_count = seen_count + 1;
		if (seen_count > w + 1) seen_count = w + 1;
		r.beta = 0;
		r.stat = ST_WARM;
		if (seen_count < w + 1) return r;
		sum_a = 0; sum_m = 0; sxy = 0; sxx = 0;
		for (int k = 0; k < w; k++) begin
			idx = (slot + WINDOW_MAX - 1 - k) % WINDOW_MAX;
			sum_a += longint'(signed'(asset_ring[idx]));
			sum_m += longint'(signed'(market_ring[idx]));
		end
		mean_a = sum_a / longint'(w);
		mean_m = sum_m / longint'(w);
		for (int k = 0; k < w; k++) begin
			idx = (slot + WINDOW_MAX - 1 - k) % WINDOW_MAX;
			da = clamp32(longint'(signed'(asset_ring[idx])) - mean_a);
			dm = clamp32(longint'(signed'(market_ring[idx])) - mean_m);
			sxy += (da * dm) / 65536;
			sxx += (dm * dm) / 65536;
		end
		wv = unbiased_reg ? w - 1 : w;
		cov = sxy / longint'(w);
		var_m = sxx / longint'(wv);
		if (var_m == 0) begin
			r.stat = ST_ZERO;
			return r;
		end
		r.beta = 32'(clamp32((cov * 65536) / var_m));
		r.stat = ST_VALID;
		return r;
	endfunction

	function automatic int pick_gap();
		if ($urandom_range(0, 3) == 0) return 0;
		if ($urandom_range(0, 15) == 0) return $urandom_range(20, 120);
		return $urandom_range(0, 4);
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			asset_price <= 0;
			market_price <= 0;
			send_gap <= 0;
		end else if (in_valid && !in_stall) begin
			expected_betas.push_back(predict_beta({asset_price, market_price}));
			if (send_gap == 0 && pending_pairs.size() > 0) begin
				{asset_price, market_price} <= pending_pairs.pop_front();
				send_gap <= pick_gap();
			end else begin
				in_valid <= 0;
			end
		end else if (!in_valid) begin
			if (send_gap > 0)
				send_gap <= send_gap - 1;
			else if (pending_pairs.size() > 0) begin
				{asset_price, market_price} <= pending_pairs.pop_front();
				in_valid <= 1;
				send_gap <= pick_gap();
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		beta_result_t e;
		if (!arst_n) begin
			out_stall <= 0;
			stall_len <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_betas.size() == 0) begin
					$display("%0t: unexpected beat beta=%0d status=%0d", $time, beta_value, status);
					error_count++;
				end else begin
					e = expected_betas.pop_front();
					if (e.beta !== beta_value) begin
						$display("%0t: beta expected %0d actual %0d", $time, e.beta, beta_value);
						error_count++;
					end
					if (e.stat !== status) begin
						$display("%0t: status expected %0d actual %0d", $time, e.stat, status);
						error_count++;
					end
				end
			end
			if (stall_len > 0) begin
				stall_len <= stall_len - 1;
				out_stall <= 1;
			end else if ($urandom_range(0, 5) == 0) begin
				stall_len <= pick_gap();
				out_stall <= 1;
			end else
				out_stall <= 0;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic write_reg(bit idx, int unsigned val);
		@(posedge clk);
		cfg_wr_en <= 1;
		cfg_index <= idx;
		cfg_data <= val[WIN_W-1:0];
		@(posedge clk);
		cfg_wr_en <= 0;
		if (idx == 0) win_reg = val & 7'h7F;
		else unbiased_reg = val & 1;
	endtask

	task automatic drain();
		wait (pending_pairs.size() == 0 && !in_valid && expected_betas.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_price();
		case ($urandom_range(0, 9))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom;
			default: return 32'h0064_0000 + $urandom_range(0, 32'h0040_0000);
		endcase
	endfunction

	task automatic queue_random(int n, int mode);
		logic [31:0] a, m;
		a = 32'h0064_0000;
		m = 32'h0064_0000;
		repeat (n) begin
			if (mode == 0) begin
				a = a + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
				m = m + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
				pending_pairs.push_back({a, m});
			end else
				pending_pairs.push_back({rand_price(), rand_price()});
		end
	endtask

	initial begin
		error_count = 0;
		cycle_count = 0;
		cfg_wr_en = 0;
		cfg_index = 0;
		cfg_data = 0;
		win_reg = WIN_RESET;
		unbiased_reg = 1;
		prev_asset = 0;
		prev_market = 0;
		slot = 0;
		seen_count = 0;
		arst_n = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;

		// directed: short window, zero prices, extremes, flat market
		write_reg(0, 2);
		pending_pairs.push_back({32'h0, 32'h0});
		pending_pairs.push_back({32'h0001_0000, 32'h0});
		pending_pairs.push_back({32'hFFFF_FFFF, 32'h0002_0000});
		pending_pairs.push_back({32'h0, 32'hFFFF_FFFF});
		pending_pairs.push_back({32'h0, 32'h0});
		pending_pairs.push_back({32'h0005_0000, 32'h0005_0000});
		pending_pairs.push_back({32'h0006_0000, 32'h0005_0000});
		pending_pairs.push_back({32'h0007_0000, 32'h0005_0000});
		pending_pairs.push_back({32'h0007_0000, 32'h0005_0001});
		pending_pairs.push_back({32'h0007_0001, 32'h0005_0000});
		pending_pairs.push_back({32'h8000_0000, 32'h0000_0001});
		pending_pairs.push_back({32'h0000_0001, 32'h8000_0000});
		pending_pairs.push_back({32'h5555_5555, 32'hAAAA_AAAA});
		pending_pairs.push_back({32'hAAAA_AAAA, 32'h5555_5555});
		drain();
		write_reg(1, 0);
		queue_random(6, 1);
		drain();
		// window out of range: clamps high and low
		write_reg(0, 127);
		write_reg(1, 1);
		queue_random(70, 0);
		drain();
		write_reg(0, 0);
		queue_random(10, 1);
		drain();

		// random phases
		write_reg(0, 64);
		queue_random(150, 0);
		queue_random(20, 1);
		drain();
		write_reg(0, 5);
		write_reg(1, 0);
		queue_random(120, 0);
		queue_random(30, 1);
		drain();
		write_reg(0, 20);
		write_reg(1, 1);
		queue_random(100, 0);
		queue_random(30, 1);
		drain();
		write_reg(0, $urandom_range(2, 64));
		write_reg(1, $urandom_range(0, 1));
		queue_random(150, 0);
		drain();

		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/rbeta_pkg.sv
hw/rtl/rbeta_div.sv
hw/rtl/rolling_beta_from_returns_top.sv
verif/testbench.sv
